FILE: rtl/mdp_pkg.sv
`timescale 1ns / 1ps
// mdp_pkg: shared types, constants and saturating helpers for the midpoint ode stepper
// used by mdp_mul and midpoint_ode_stepper; no dependencies

package mdp_pkg;

	localparam int REPORT_DEPTH = 16;
	localparam int FRAC_BITS    = 32;

	localparam int DW     = 48;
	localparam int TOL_W  = 47;
	localparam int CNT_W  = 5;
	localparam int OP_W   = 2;
	localparam int IDX_W  = 4;
	localparam int SLOT_W = 4;
	localparam int CFG_IW = 2;
	localparam int PROD_W = 2 * DW;
	localparam int HALF_W = DW / 2;
	localparam int PP_W   = HALF_W + DW;

	localparam int RAM_AW = (REPORT_DEPTH > 1) ? $clog2(REPORT_DEPTH) : 1;
	localparam int NR_W   = $clog2(REPORT_DEPTH + 1);

	// opcodes
	localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_START_X = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_START_Y = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_TOL     = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_COUNT   = 2'd3;

	// reset values of the configuration registers
	localparam logic [DW-1:0]    START_X_RST = 48'd0;
	localparam logic [DW-1:0]    START_Y_RST = 48'd12884901888;
	localparam logic [TOL_W-1:0] TOL_RST     = 47'd4295;
	localparam logic [CNT_W-1:0] COUNT_RST   = 5'd11;

	// saturation bounds
	localparam logic [DW-1:0] MAXV     = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINV     = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] NEG_MAXV = {1'b1, {(DW-2){1'b0}}, 1'b1};

	// fixed-point constants
	localparam logic [DW-1:0] FX_THREE = DW'(3) << FRAC_BITS;
	localparam logic [DW-1:0] FX_HALF  = DW'(1) << (FRAC_BITS - 1);

	// product rounding and magnitude limit
	localparam logic [PROD_W-1:0] PROD_RND = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_W-1:0] PROD_LIM = PROD_W'(1) << (DW - 1 + FRAC_BITS);

	typedef struct packed {
		logic          ovf;
		logic [DW-1:0] v;
	} sat_t;

	function automatic sat_t sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] s;
		sat_t        r;
		s = {a[DW-1], a} + {b[DW-1], b};
		r.ovf = s[DW] ^ s[DW-1];
		if (r.ovf) begin
			r.v = s[DW] ? MINV : MAXV;
		end else begin
			r.v = s[DW-1:0];
		end
		return r;
	endfunction

	function automatic sat_t sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] s;
		sat_t        r;
		s = {a[DW-1], a} - {b[DW-1], b};
		r.ovf = s[DW] ^ s[DW-1];
		if (r.ovf) begin
			r.v = s[DW] ? MINV : MAXV;
		end else begin
			r.v = s[DW-1:0];
		end
		return r;
	endfunction

	// magnitude of a two's complement value, most negative maps to 2^(DW-1)
	function automatic logic [DW-1:0] mag(input logic [DW-1:0] a);
		return a[DW-1] ? (DW'(0) - a) : a;
	endfunction

endpackage

FILE: rtl/mdp_ram.sv
`timescale 1ns / 1ps
// mdp_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies

module mdp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/mdp_mul.sv
`timescale 1ns / 1ps
// mdp_mul: multi-cycle saturating fixed-point multiplier, two 24x48 partial products
// depends on mdp_pkg

module mdp_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [mdp_pkg::DW-1:0] a,
	input  logic [mdp_pkg::DW-1:0] b,
	output logic                  done,
	output logic [mdp_pkg::DW-1:0] res,
	output logic                  ovf
);
	import mdp_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_LO   = 3'd1;
	localparam logic [2:0] PH_HI   = 3'd2;
	localparam logic [2:0] PH_SUM  = 3'd3;
	localparam logic [2:0] PH_OUT  = 3'd4;

	logic [2:0]        phase_q;
	logic [DW-1:0]     ma_q;
	logic [DW-1:0]     mb_q;
	logic              neg_q;
	logic [PP_W-1:0]   pp_q;
	logic [PROD_W-1:0] acc_q;
	logic              done_q;
	logic [DW-1:0]     res_q;
	logic              ovf_q;

	logic              over;
	logic [DW-2:0]     quo;

	assign over = (acc_q >= PROD_LIM);
	assign quo  = acc_q[FRAC_BITS +: (DW-1)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_LO;
					end
				end
				PH_LO:  phase_q <= PH_HI;
				PH_HI:  phase_q <= PH_SUM;
				PH_SUM: phase_q <= PH_OUT;
				PH_OUT: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					ma_q  <= mag(a);
					mb_q  <= mag(b);
					neg_q <= a[DW-1] ^ b[DW-1];
				end
			end
			PH_LO: begin
				pp_q <= PP_W'(ma_q[HALF_W-1:0]) * PP_W'(mb_q);
			end
			PH_HI: begin
				acc_q <= PROD_W'(pp_q) + PROD_RND;
				pp_q  <= PP_W'(ma_q[DW-1:HALF_W]) * PP_W'(mb_q);
			end
			PH_SUM: begin
				acc_q <= acc_q + (PROD_W'(pp_q) << HALF_W);
			end
			PH_OUT: begin
				ovf_q <= over;
				if (over) begin
					res_q <= neg_q ? NEG_MAXV : MAXV;
				end else begin
					res_q <= neg_q ? (DW'(0) - {1'b0, quo}) : {1'b0, quo};
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;
	assign ovf  = ovf_q;

endmodule

FILE: rtl/midpoint_ode_stepper.sv
`timescale 1ns / 1ps
// midpoint_ode_stepper: top level, explicit midpoint integrator of y' = x*y^2 + 3*x*y
// depends on mdp_pkg, mdp_ram, mdp_mul

// Integrates y' = x*y^2 + 3*x*y in signed Q16.32 with the explicit midpoint
// method. A restart transaction reloads x and y from start_x / start_y and clears
// the report index and the overflow flag; a load transaction writes one reporting
// point into a 16-entry ram; a step transaction gives the next grid x. A step
// emits one output transaction (y, slot, sticky overflow) when x lies strictly
// within match_tolerance of the next reporting point and fewer than both
// report_count and 16 points have been reported. Restart, load and unused
// opcodes do not stall the input channel. A step reads the reporting point and
// tests the match in ST_PT, then runs nine products through the single shared
// multiplier (two 24x48 partial products, accumulate, round and saturate, then
// the saturating add that consumes the result), and hands the result over in
// ST_FIN. The output register lets the next transaction enter while a result
// still waits; a step that matches holds in ST_FIN until the output register
// is free. Reporting points never loaded read as arbitrary values.

module midpoint_ode_stepper (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mdp_pkg::OP_W-1:0]     op,
	input  logic [mdp_pkg::DW-1:0]       x_point,
	input  logic [mdp_pkg::IDX_W-1:0]    point_index,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mdp_pkg::DW-1:0]       y_value,
	output logic [mdp_pkg::SLOT_W-1:0]   report_slot,
	output logic                         overflowed,
	// configuration write port
	input  logic                         cfg_we,
	input  logic [mdp_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [mdp_pkg::DW-1:0]       cfg_data
);
	import mdp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PT   = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// product sequence: k1 = xy*y + xy*3, hh = h/2, ym = y + k1*hh,
	// k2 = xy'*ym + xy'*3 at the midpoint, y += h*k2
	localparam logic [3:0] M_XY1  = 4'd0;
	localparam logic [3:0] M_XYY1 = 4'd1;
	localparam logic [3:0] M_XY31 = 4'd2;
	localparam logic [3:0] M_HH   = 4'd3;
	localparam logic [3:0] M_KHH  = 4'd4;
	localparam logic [3:0] M_XY2  = 4'd5;
	localparam logic [3:0] M_XYY2 = 4'd6;
	localparam logic [3:0] M_XY32 = 4'd7;
	localparam logic [3:0] M_HK2  = 4'd8;

	// configuration registers
	logic [DW-1:0]    start_x_q;
	logic [DW-1:0]    start_y_q;
	logic [TOL_W-1:0] tol_q;
	logic [CNT_W-1:0] count_q;

	// integrator state
	logic [DW-1:0]    y_now_q;
	logic [DW-1:0]    x_prev_q;
	logic [NR_W-1:0]  next_report_q;
	logic             sticky_q;

	// step working registers
	logic [1:0]       state_q;
	logic [3:0]       mul_idx_q;
	logic             mstart_q;
	logic [DW-1:0]    x_q;
	logic [DW-1:0]    h_q;
	logic [DW-1:0]    xy_q;
	logic [DW-1:0]    pa_q;
	logic [DW-1:0]    k_q;
	logic [DW-1:0]    hh_q;
	logic [DW-1:0]    xm_q;
	logic [DW-1:0]    ym_q;
	logic             match_q;

	// output register
	logic              out_valid_q;
	logic [DW-1:0]     y_value_q;
	logic [SLOT_W-1:0] report_slot_q;
	logic              overflowed_q;

	logic              in_acc;
	logic              ram_we;
	logic              ram_re;
	logic [DW-1:0]     point;
	logic [DW-1:0]     mul_a;
	logic [DW-1:0]     mul_b;
	logic              mul_done;
	logic [DW-1:0]     mul_res;
	logic              mul_ovf;
	logic [DW-1:0]     post_a;
	logic              post_add;
	sat_t              post_sum;
	sat_t              h_diff;
	logic [DW:0]       x_diff;
	logic [DW:0]       x_diff_mag;
	logic              in_window;
	logic              slot_left;
	logic              out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// reporting point store
	assign ram_we = in_acc && (op == OP_LOAD) && (32'(point_index) < 32'(REPORT_DEPTH));
	assign ram_re = in_acc && (op == OP_STEP);

	mdp_ram #(
		.WIDTH(DW),
		.DEPTH(REPORT_DEPTH)
	) u_points (
		.clk  (clk),
		.we   (ram_we),
		.waddr(RAM_AW'(point_index)),
		.wdata(x_point),
		.re   (ram_re),
		.raddr(next_report_q[RAM_AW-1:0]),
		.rdata(point)
	);

	// operand selection for the shared multiplier
	always_comb begin
		case (mul_idx_q)
			M_XY1:   begin mul_a = x_prev_q; mul_b = y_now_q;  end
			M_XYY1:  begin mul_a = xy_q;     mul_b = y_now_q;  end
			M_XY31:  begin mul_a = xy_q;     mul_b = FX_THREE; end
			M_HH:    begin mul_a = h_q;      mul_b = FX_HALF;  end
			M_KHH:   begin mul_a = k_q;      mul_b = hh_q;     end
			M_XY2:   begin mul_a = xm_q;     mul_b = ym_q;     end
			M_XYY2:  begin mul_a = xy_q;     mul_b = ym_q;     end
			M_XY32:  begin mul_a = xy_q;     mul_b = FX_THREE; end
			M_HK2:   begin mul_a = h_q;      mul_b = k_q;      end
			default: begin mul_a = h_q;      mul_b = k_q;      end
		endcase
	end

	mdp_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mstart_q),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.res   (mul_res),
		.ovf   (mul_ovf)
	);

	// saturating add that follows some of the products, one adder shared by all of them
	always_comb begin
		case (mul_idx_q)
			M_XY31, M_XY32: begin post_a = pa_q;     post_add = 1'b1; end
			M_HH:           begin post_a = x_prev_q; post_add = 1'b1; end
			M_KHH, M_HK2:   begin post_a = y_now_q;  post_add = 1'b1; end
			default:        begin post_a = y_now_q;  post_add = 1'b0; end
		endcase
	end

	assign post_sum = sat_add(post_a, mul_res);
	assign h_diff   = sat_sub(x_point, x_prev_q);

	// match test against the reporting point, exact distance without saturation
	assign x_diff     = {x_q[DW-1], x_q} - {point[DW-1], point};
	assign x_diff_mag = x_diff[DW] ? ((DW+1)'(0) - x_diff) : x_diff;
	assign in_window  = (x_diff_mag < (DW+1)'(tol_q));
	assign slot_left  = (32'(next_report_q) < 32'(count_q))
		&& (32'(next_report_q) < 32'(REPORT_DEPTH));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= START_X_RST;
			start_y_q <= START_Y_RST;
			tol_q     <= TOL_RST;
			count_q   <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_X: start_x_q <= cfg_data;
				CFG_START_Y: start_y_q <= cfg_data;
				CFG_TOL:     tol_q     <= cfg_data[TOL_W-1:0];
				CFG_COUNT:   count_q   <= cfg_data[CNT_W-1:0];
				default:     ;
			endcase
		end
	end

	// sequencer and integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mul_idx_q     <= M_XY1;
			mstart_q      <= 1'b0;
			y_now_q       <= START_Y_RST;
			x_prev_q      <= START_X_RST;
			next_report_q <= '0;
			sticky_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			mstart_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (op)
							OP_RESTART: begin
								x_prev_q      <= start_x_q;
								y_now_q       <= start_y_q;
								next_report_q <= '0;
								sticky_q      <= 1'b0;
							end
							OP_STEP: begin
								sticky_q <= sticky_q | h_diff.ovf;
								state_q  <= ST_PT;
							end
							default: ;
						endcase
					end
				end
				ST_PT: begin
					// reporting point is out of the ram now, kick off the first product
					mul_idx_q <= M_XY1;
					mstart_q  <= 1'b1;
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) begin
						sticky_q <= sticky_q | mul_ovf | (post_add & post_sum.ovf);
						if (mul_idx_q == M_HK2) begin
							y_now_q  <= post_sum.v;
							x_prev_q <= x_q;
							state_q  <= ST_FIN;
						end else begin
							mul_idx_q <= mul_idx_q + 4'd1;
							mstart_q  <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (!match_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q   <= 1'b1;
						next_report_q <= next_report_q + NR_W'(1);
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// step datapath registers
	always_ff @(posedge clk) begin
		if (in_acc && (op == OP_STEP)) begin
			x_q <= x_point;
			h_q <= h_diff.v;
		end
		if (state_q == ST_PT) begin
			match_q <= slot_left && in_window;
		end
		if ((state_q == ST_MUL) && mul_done) begin
			case (mul_idx_q)
				M_XY1:   xy_q <= mul_res;
				M_XYY1:  pa_q <= mul_res;
				M_XY31:  k_q  <= post_sum.v;
				M_HH: begin
					hh_q <= mul_res;
					xm_q <= post_sum.v;
				end
				M_KHH:   ym_q <= post_sum.v;
				M_XY2:   xy_q <= mul_res;
				M_XYY2:  pa_q <= mul_res;
				M_XY32:  k_q  <= post_sum.v;
				default: ;
			endcase
		end
		if ((state_q == ST_FIN) && match_q && out_free) begin
			y_value_q     <= y_now_q;
			report_slot_q <= SLOT_W'(next_report_q);
			overflowed_q  <= sticky_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign y_value     = y_value_q;
	assign report_slot = report_slot_q;
	assign overflowed  = overflowed_q;

endmodule
